FILE: src/lprd_pkg.sv
package lprd_pkg;

    // Parser phases, one per position in the document grammar.
    typedef enum logic [3:0] {
        PH_MAGIC     = 4'd0,
        PH_VER_WS    = 4'd1,
        PH_VER_POS   = 4'd2,
        PH_VER_NEG   = 4'd3,
        PH_ENT_KW    = 4'd4,
        PH_ENT_NUM   = 4'd5,
        PH_CHAR_KW   = 4'd6,
        PH_CHAR_NUM  = 4'd7,
        PH_CHAR_DATA = 4'd8,
        PH_CHAR_NL   = 4'd9,
        PH_TEXT_KW   = 4'd10,
        PH_TEXT_NUM  = 4'd11,
        PH_TEXT_DATA = 4'd12,
        PH_TEXT_NL   = 4'd13,
        PH_DRAIN     = 4'd14
    } t_phase;

    // Event codes carried on the result channel.
    typedef enum logic [2:0] {
        EV_NAME_BYTE  = 3'd0,
        EV_TEXT_BYTE  = 3'd1,
        EV_NAME_DONE  = 3'd2,
        EV_ENTRY_DONE = 3'd3,
        EV_ACCEPT     = 3'd4,
        EV_REJECT     = 3'd5
    } t_kind;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_file;
    } t_in_item;

    typedef struct packed {
        t_kind       event_kind;
        logic [7:0]  out_byte;
        logic [31:0] entry_index;
        logic        last_of_run;
    } t_out_item;

    // Up to two result items produced by one input item.
    typedef struct packed {
        logic      v0;
        logic      v1;
        t_out_item i0;
        t_out_item i1;
    } t_res_pair;

    // Header magic word followed by a space.
    localparam logic [0:12][7:0] HDR_KW = {
        8'h43, 8'h4F, 8'h4D, 8'h49, 8'h43, 8'h43, 8'h48,
        8'h41, 8'h54, 8'h44, 8'h4F, 8'h43, 8'h20
    };
    // "ENTRIES "
    localparam logic [0:7][7:0] ENT_KW = {
        8'h45, 8'h4E, 8'h54, 8'h52, 8'h49, 8'h45, 8'h53, 8'h20
    };
    // "CHAR "
    localparam logic [0:4][7:0] CHAR_KW = {8'h43, 8'h48, 8'h41, 8'h52, 8'h20};
    // "TEXT "
    localparam logic [0:4][7:0] TEXT_KW = {8'h54, 8'h45, 8'h58, 8'h54, 8'h20};

    localparam logic [3:0] HDR_LAST  = 4'd12;
    localparam logic [3:0] ENT_LAST  = 4'd7;
    localparam logic [3:0] FLD_LAST  = 4'd4;

    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    // Saturation point of the version accumulator.
    localparam logic [8:0] VER_SAT = 9'd256;

endpackage

FILE: src/lprd_parser.sv
module lprd_parser
    import lprd_pkg::*;
#(
    parameter int COUNT_BITS = 32
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_take,
    input  t_in_item  i_item,
    input  logic [7:0] i_exp_ver,
    output t_res_pair o_res
);

    // Parser state.
    t_phase                r_phase, n_phase;
    logic [3:0]            r_pos, n_pos;
    logic [COUNT_BITS-1:0] r_acc, n_acc;
    logic [8:0]            r_ver, n_ver;
    logic                  r_seen, n_seen;
    logic [COUNT_BITS-1:0] r_total, n_total;
    logic [COUNT_BITS-1:0] r_cnt, n_cnt;
    logic [COUNT_BITS-1:0] r_rem, n_rem;

    logic [7:0]            byte_in;
    logic                  is_digit;
    logic [3:0]            digit;
    logic [COUNT_BITS+3:0] acc_ext;
    logic [COUNT_BITS+3:0] acc10;
    logic                  acc_ovf;
    logic [12:0]           ver_ext;
    logic [12:0]           ver10;
    logic                  ver_ok;
    logic [COUNT_BITS-1:0] cnt_inc;
    logic [COUNT_BITS+31:0] cnt_ext;
    logic [COUNT_BITS+31:0] cnt_inc_ext;
    logic [COUNT_BITS+31:0] ncnt_ext;

    logic [7:0]            kw_ch;
    logic                  kw_in_range;
    logic                  kw_last;
    t_phase                kw_next;
    logic                  kw_hit;

    logic                  ev0_v, ev1_v;
    t_kind                 ev0_kind, ev1_kind;
    logic [7:0]            ev0_byte;
    logic [31:0]           ev0_idx, ev1_idx;
    logic                  verdict;

    assign byte_in  = i_item.in_byte;
    assign is_digit = (byte_in >= CH_ZERO) && (byte_in <= CH_NINE);
    assign digit    = byte_in[3:0];

    // Decimal accumulate with overflow detection for counts and lengths.
    assign acc_ext = {4'd0, r_acc};
    assign acc10   = (acc_ext << 3) + (acc_ext << 1) + {{COUNT_BITS{1'b0}}, digit};
    assign acc_ovf = |acc10[COUNT_BITS+3:COUNT_BITS];

    // Version accumulate; saturates just above the largest byte value.
    assign ver_ext = {4'd0, r_ver};
    assign ver10   = (ver_ext << 3) + (ver_ext << 1) + {9'd0, digit};
    assign ver_ok  = (r_phase == PH_VER_NEG) ? ((r_ver == 9'd0) && (i_exp_ver == 8'd0))
                                             : (r_ver == {1'b0, i_exp_ver});

    // Entry counter as seen on the 32-bit index field.
    assign cnt_inc     = r_cnt + {{(COUNT_BITS-1){1'b0}}, 1'b1};
    assign cnt_ext     = {32'd0, r_cnt};
    assign cnt_inc_ext = {32'd0, cnt_inc};
    assign ncnt_ext    = {32'd0, n_cnt};

    // Expected keyword byte for the current keyword phase.
    always_comb begin
        kw_ch       = HDR_KW[0];
        kw_in_range = 1'b0;
        kw_last     = 1'b0;
        kw_next     = PH_DRAIN;
        case (r_phase)
            PH_MAGIC: begin
                kw_in_range = (r_pos <= HDR_LAST);
                kw_ch       = HDR_KW[r_pos];
                kw_last     = (r_pos == HDR_LAST);
                kw_next     = PH_VER_WS;
            end
            PH_ENT_KW: begin
                kw_in_range = (r_pos <= ENT_LAST);
                kw_ch       = ENT_KW[r_pos[2:0]];
                kw_last     = (r_pos == ENT_LAST);
                kw_next     = PH_ENT_NUM;
            end
            PH_CHAR_KW: begin
                kw_in_range = (r_pos <= FLD_LAST);
                kw_ch       = CHAR_KW[r_pos[2:0]];
                kw_last     = (r_pos == FLD_LAST);
                kw_next     = PH_CHAR_NUM;
            end
            PH_TEXT_KW: begin
                kw_in_range = (r_pos <= FLD_LAST);
                kw_ch       = TEXT_KW[r_pos[2:0]];
                kw_last     = (r_pos == FLD_LAST);
                kw_next     = PH_TEXT_NUM;
            end
            default: begin
                kw_in_range = 1'b0;
            end
        endcase
    end

    assign kw_hit = kw_in_range && (byte_in == kw_ch);

    // Next state and the results of one input item.
    always_comb begin
        n_phase  = r_phase;
        n_pos    = r_pos;
        n_acc    = r_acc;
        n_ver    = r_ver;
        n_seen   = r_seen;
        n_total  = r_total;
        n_cnt    = r_cnt;
        n_rem    = r_rem;
        ev0_v    = 1'b0;
        ev0_kind = EV_REJECT;
        ev0_byte = 8'd0;
        ev0_idx  = cnt_ext[31:0];
        ev1_v    = 1'b0;
        ev1_kind = EV_REJECT;
        ev1_idx  = cnt_ext[31:0];
        verdict  = 1'b0;

        case (r_phase)
            PH_MAGIC, PH_ENT_KW, PH_CHAR_KW, PH_TEXT_KW: begin
                if (kw_hit) begin
                    if (kw_last) begin
                        n_pos   = 4'd0;
                        n_acc   = '0;
                        n_ver   = 9'd0;
                        n_seen  = 1'b0;
                        n_phase = kw_next;
                    end else begin
                        n_pos = r_pos + 4'd1;
                    end
                end else begin
                    ev0_v   = 1'b1;
                    n_phase = PH_DRAIN;
                    verdict = 1'b1;
                end
            end

            PH_VER_WS, PH_VER_POS, PH_VER_NEG: begin
                if (r_phase == PH_VER_WS && (byte_in == CH_SPACE || byte_in == CH_TAB ||
                        byte_in == CH_VT || byte_in == CH_FF || byte_in == CH_CR)) begin
                    n_phase = PH_VER_WS;
                end else if (r_phase == PH_VER_WS && byte_in == CH_PLUS) begin
                    n_phase = PH_VER_POS;
                end else if (r_phase == PH_VER_WS && byte_in == CH_MINUS) begin
                    n_phase = PH_VER_NEG;
                end else if (is_digit) begin
                    if (r_phase == PH_VER_WS) begin
                        n_phase = PH_VER_POS;
                    end
                    n_ver  = (ver10 > {4'd0, VER_SAT}) ? VER_SAT : ver10[8:0];
                    n_seen = 1'b1;
                end else if (r_phase != PH_VER_WS && byte_in == CH_LF && r_seen) begin
                    if (ver_ok) begin
                        n_phase = PH_ENT_KW;
                        n_pos   = 4'd0;
                        n_acc   = '0;
                        n_ver   = 9'd0;
                        n_seen  = 1'b0;
                    end else begin
                        ev0_v   = 1'b1;
                        n_phase = PH_DRAIN;
                        verdict = 1'b1;
                    end
                end else begin
                    ev0_v   = 1'b1;
                    n_phase = PH_DRAIN;
                    verdict = 1'b1;
                end
            end

            PH_ENT_NUM, PH_CHAR_NUM, PH_TEXT_NUM: begin
                if (is_digit) begin
                    if (acc_ovf) begin
                        ev0_v   = 1'b1;
                        n_phase = PH_DRAIN;
                        verdict = 1'b1;
                    end else begin
                        n_acc  = acc10[COUNT_BITS-1:0];
                        n_seen = 1'b1;
                    end
                end else if (byte_in == CH_LF && r_seen) begin
                    if (r_phase == PH_ENT_NUM) begin
                        n_total = r_acc;
                        n_cnt   = '0;
                        if (r_acc == '0) begin
                            ev0_v    = 1'b1;
                            ev0_kind = EV_ACCEPT;
                            ev0_idx  = 32'd0;
                            n_phase  = PH_DRAIN;
                            verdict  = 1'b1;
                        end else begin
                            n_phase = PH_CHAR_KW;
                        end
                    end else begin
                        n_rem = r_acc;
                        if (r_phase == PH_CHAR_NUM) begin
                            n_phase = (r_acc != '0) ? PH_CHAR_DATA : PH_CHAR_NL;
                        end else begin
                            n_phase = (r_acc != '0) ? PH_TEXT_DATA : PH_TEXT_NL;
                        end
                    end
                end else begin
                    ev0_v   = 1'b1;
                    n_phase = PH_DRAIN;
                    verdict = 1'b1;
                end
            end

            PH_CHAR_DATA, PH_TEXT_DATA: begin
                ev0_v    = 1'b1;
                ev0_kind = (r_phase == PH_CHAR_DATA) ? EV_NAME_BYTE : EV_TEXT_BYTE;
                ev0_byte = byte_in;
                n_rem    = r_rem - {{(COUNT_BITS-1){1'b0}}, 1'b1};
                if (r_rem == {{(COUNT_BITS-1){1'b0}}, 1'b1}) begin
                    n_phase = (r_phase == PH_CHAR_DATA) ? PH_CHAR_NL : PH_TEXT_NL;
                end
            end

            PH_CHAR_NL: begin
                ev0_v = 1'b1;
                if (byte_in == CH_LF) begin
                    ev0_kind = EV_NAME_DONE;
                    n_phase  = PH_TEXT_KW;
                    n_pos    = 4'd0;
                end else begin
                    n_phase = PH_DRAIN;
                    verdict = 1'b1;
                end
            end

            PH_TEXT_NL: begin
                ev0_v = 1'b1;
                if (byte_in == CH_LF) begin
                    ev0_kind = EV_ENTRY_DONE;
                    n_cnt    = cnt_inc;
                    if (cnt_inc == r_total) begin
                        ev1_v    = 1'b1;
                        ev1_kind = EV_ACCEPT;
                        ev1_idx  = cnt_inc_ext[31:0];
                        n_phase  = PH_DRAIN;
                        verdict  = 1'b1;
                    end else begin
                        n_phase = PH_CHAR_KW;
                        n_pos   = 4'd0;
                    end
                end else begin
                    n_phase = PH_DRAIN;
                    verdict = 1'b1;
                end
            end

            default: begin
                n_phase = PH_DRAIN;
            end
        endcase

        // End of file: reject an unfinished document, then rearm.
        if (i_item.end_of_file) begin
            if (!verdict && n_phase != PH_DRAIN) begin
                if (ev0_v) begin
                    ev1_v    = 1'b1;
                    ev1_kind = EV_REJECT;
                    ev1_idx  = ncnt_ext[31:0];
                end else begin
                    ev0_v    = 1'b1;
                    ev0_kind = EV_REJECT;
                    ev0_byte = 8'd0;
                    ev0_idx  = ncnt_ext[31:0];
                end
            end
            n_phase = PH_MAGIC;
            n_pos   = 4'd0;
            n_acc   = '0;
            n_ver   = 9'd0;
            n_seen  = 1'b0;
            n_total = '0;
            n_cnt   = '0;
            n_rem   = '0;
        end
    end

    // Pack the results for the output queue.
    always_comb begin
        o_res.v0             = ev0_v;
        o_res.v1             = ev1_v;
        o_res.i0.event_kind  = ev0_kind;
        o_res.i0.out_byte    = ev0_byte;
        o_res.i0.entry_index = ev0_idx;
        o_res.i0.last_of_run = !ev1_v;
        o_res.i1.event_kind  = ev1_kind;
        o_res.i1.out_byte    = 8'd0;
        o_res.i1.entry_index = ev1_idx;
        o_res.i1.last_of_run = 1'b1;
    end

    // State registers advance only on an accepted item.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_MAGIC;
            r_pos   <= 4'd0;
            r_acc   <= '0;
            r_ver   <= 9'd0;
            r_seen  <= 1'b0;
            r_total <= '0;
            r_cnt   <= '0;
            r_rem   <= '0;
        end else if (i_take) begin
            r_phase <= n_phase;
            r_pos   <= n_pos;
            r_acc   <= n_acc;
            r_ver   <= n_ver;
            r_seen  <= n_seen;
            r_total <= n_total;
            r_cnt   <= n_cnt;
            r_rem   <= n_rem;
        end
    end

endmodule

FILE: src/lprd_outq.sv
module lprd_outq
    import lprd_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_res_pair i_pair,
    input  logic      i_stall,
    output logic      o_full,
    output logic      o_valid,
    output t_out_item o_item
);

    // Head is the visible result register; tail holds a second result.
    t_out_item r_head, n_head;
    t_out_item r_tail, n_tail;
    logic      r_head_v, n_head_v;
    logic      r_tail_v, n_tail_v;
    logic      take;

    assign o_valid = r_head_v;
    assign o_item  = r_head;
    assign take    = r_head_v && !i_stall;

    // Room for two new results exists once the queue empties this cycle.
    assign o_full  = !(!r_head_v || (take && !r_tail_v));

    always_comb begin
        n_head   = r_head;
        n_tail   = r_tail;
        n_head_v = r_head_v;
        n_tail_v = r_tail_v;
        if (i_push) begin
            n_head   = i_pair.i0;
            n_head_v = i_pair.v0;
            n_tail   = i_pair.i1;
            n_tail_v = i_pair.v1;
        end else if (take) begin
            n_head   = r_tail;
            n_head_v = r_tail_v;
            n_tail_v = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head_v <= 1'b0;
            r_tail_v <= 1'b0;
        end else begin
            r_head_v <= n_head_v;
            r_tail_v <= n_tail_v;
        end
        r_head <= n_head;
        r_tail <= n_tail;
    end

`ifndef ASSERT_OFF
    a_tail_needs_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tail_v |-> r_head_v)
        else $error("second result held without a first");

    a_push_has_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (!r_head_v || (take && !r_tail_v)))
        else $error("results pushed into a queue without room");

    a_pair_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && i_pair.v1) |-> i_pair.v0)
        else $error("second result without a first");

    a_push_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && i_pair.v0) |=> (o_valid && o_item == $past(i_pair.i0)))
        else $error("pushed result not presented");

    a_tail_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tail_v |-> (r_tail.last_of_run && !r_head.last_of_run))
        else $error("run end marking wrong for a two-result item");
`endif

endmodule

FILE: src/length_prefixed_record_deframer_core.sv
// Deframes a length-prefixed text record document that arrives one byte per item, with an
// end-of-file flag on the last byte. It checks the header line and its version against the
// expected_version register, then the entry count line and each name and text field, and
// emits tagged payload bytes, name-done and entry-done events, and one accepted or rejected
// verdict; later bytes are dropped until end of file, which rearms the parser. A byte is
// accepted every cycle when it causes at most one result and the output is taken; a byte that
// causes two results (an entry done with the final verdict, or a result followed by a
// rejection at an early end of file) occupies both slots of the two-entry output queue and
// holds the input off while the second result waits in the tail slot. The configuration
// register may be written only while the block is idle.
module length_prefixed_record_deframer_core
    import lprd_pkg::*;
#(
    parameter int COUNT_BITS = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  t_in_item   i_item,
    output logic       o_valid,
    input  logic       i_stall,
    output t_out_item  o_item,
    input  logic       i_cfg_we,
    input  logic [7:0] i_cfg_wdata
);

    logic [7:0] r_exp_ver;
    logic       take;
    logic       q_full;
    t_res_pair  res;

    // Expected version register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp_ver <= 8'd1;
        end else if (i_cfg_we) begin
            r_exp_ver <= i_cfg_wdata;
        end
    end

    // An item is taken whenever the output queue can hold its results.
    assign o_stall = q_full;
    assign take    = i_valid && !q_full;

    lprd_parser #(
        .COUNT_BITS(COUNT_BITS)
    ) u_parser (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_take    (take),
        .i_item    (i_item),
        .i_exp_ver (r_exp_ver),
        .o_res     (res)
    );

    lprd_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (take),
        .i_pair  (res),
        .i_stall (i_stall),
        .o_full  (q_full),
        .o_valid (o_valid),
        .o_item  (o_item)
    );

endmodule

FILE: dv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
    import lprd_pkg::*;

    localparam int CLK_HALF = 5;
    localparam int ITEM_TARGET = 1450;
    localparam int N_PHASES = 8;
    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES = 80;
    localparam int CYCLE_LIMIT = 400000;
    localparam int MAX_REPORTS = 40;
    localparam longint unsigned COUNT_MAX = 64'hFFFF_FFFF;

    // One stimulus item, with an optional hand-written expectation.
    typedef struct {
        logic [7:0] b;
        logic       eof;
        bit         typed;
        int         n_res;
        t_kind      kind;
    } t_stim_row;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_valid;
    logic       o_stall;
    t_in_item   i_item;
    logic       o_valid;
    logic       i_stall;
    t_out_item  o_item;
    logic       i_cfg_we;
    logic [7:0] i_cfg_wdata;

    // Parser state mirrored by the testbench.
    t_phase          pstate;
    int              kw_idx;
    longint unsigned num_acc;
    bit              got_digit;
    longint unsigned n_entries;
    longint unsigned entry_no;
    longint unsigned left_bytes;
    bit              verdict_seen;
    logic [7:0]      cfg_version;

    t_out_item step_res[$];
    t_out_item events_due[$];
    logic [7:0] doc_q[$];
    t_stim_row dir_rows[$];
    t_stim_row cur_row;

    int send_gap_pct = 0;
    int recv_hold_pct = 0;
    bit hold_go = 1'b0;
    int hold_left = 0;

    int n_cycles = 0;
    int n_useful = 0;
    int n_bytes = 0;
    int n_docs = 0;
    int n_checked = 0;
    int n_accepted = 0;
    int n_rejected = 0;
    int n_fail = 0;
    int n_settings = 0;

    length_prefixed_record_deframer_core DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_item      (i_item),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_item      (o_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    // Free-running clock.
    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // Watchdog on the total run length.
    always @(posedge i_clk) begin
        n_cycles++;
        if (n_cycles > CYCLE_LIMIT) begin
            $display("Run stopped at cycle %0d with %0d events outstanding.",
                     n_cycles, events_due.size());
            $display("TB_ERROR");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Deframing predictor
    // ---------------------------------------------------------------

    function automatic void clear_parser();
        pstate = PH_MAGIC;
        kw_idx = 0;
        num_acc = 0;
        got_digit = 1'b0;
        n_entries = 0;
        entry_no = 0;
        left_bytes = 0;
    endfunction

    function automatic void emit(t_kind k, logic [7:0] b, longint unsigned idx);
        step_res.insert(step_res.size(), t_out_item'{event_kind: k, out_byte: b,
                        entry_index: 32'(idx), last_of_run: 1'b0});
    endfunction

    // The verdict ends the document; later bytes are dropped until end of file.
    function automatic void give_verdict(t_kind k);
        emit(k, 8'h00, entry_no);
        pstate = PH_DRAIN;
        verdict_seen = 1'b1;
    endfunction

    function automatic void match_keyword(logic [7:0] b, t_phase nxt);
        logic [7:0] want;
        int last;
        case (pstate)
            PH_MAGIC: begin
                want = HDR_KW[kw_idx];
                last = HDR_LAST;
            end
            PH_ENT_KW: begin
                want = ENT_KW[kw_idx];
                last = ENT_LAST;
            end
            PH_CHAR_KW: begin
                want = CHAR_KW[kw_idx];
                last = FLD_LAST;
            end
            default: begin
                want = TEXT_KW[kw_idx];
                last = FLD_LAST;
            end
        endcase
        if (b == want) begin
            if (kw_idx == last) begin
                kw_idx = 0;
                num_acc = 0;
                got_digit = 1'b0;
                pstate = nxt;
            end else begin
                kw_idx++;
            end
        end else begin
            give_verdict(EV_REJECT);
        end
    endfunction

    // Returns 1 when a newline closes a well-formed count.
    function automatic bit count_digit(logic [7:0] b);
        longint unsigned d;
        if (b >= CH_ZERO && b <= CH_NINE) begin
            d = b - CH_ZERO;
            if (num_acc > (COUNT_MAX - d) / 10) begin
                give_verdict(EV_REJECT);
            end else begin
                num_acc = num_acc * 10 + d;
                got_digit = 1'b1;
            end
            return 1'b0;
        end
        if (b == CH_LF && got_digit)
            return 1'b1;
        give_verdict(EV_REJECT);
        return 1'b0;
    endfunction

    // The version saturates at 256 so that large magnitudes never match.
    function automatic void version_digit(logic [7:0] b);
        bit ok;
        if (b >= CH_ZERO && b <= CH_NINE) begin
            num_acc = num_acc * 10 + (b - CH_ZERO);
            if (num_acc > 256)
                num_acc = 256;
            got_digit = 1'b1;
        end else if (b == CH_LF && got_digit) begin
            if (pstate == PH_VER_NEG)
                ok = (num_acc == 0) && (cfg_version == 8'd0);
            else
                ok = (num_acc == cfg_version);
            if (ok) begin
                pstate = PH_ENT_KW;
                kw_idx = 0;
                num_acc = 0;
                got_digit = 1'b0;
            end else begin
                give_verdict(EV_REJECT);
            end
        end else begin
            give_verdict(EV_REJECT);
        end
    endfunction

    function automatic void deframe_step(logic [7:0] b, logic eof);
        step_res.delete();
        verdict_seen = 1'b0;
        case (pstate)
            PH_MAGIC: match_keyword(b, PH_VER_WS);
            PH_VER_WS: begin
                if (b == CH_SPACE || b == CH_TAB || b == CH_VT || b == CH_FF
                        || b == CH_CR) begin
                    // Leading whitespace is skipped.
                end else if (b == CH_PLUS) begin
                    pstate = PH_VER_POS;
                end else if (b == CH_MINUS) begin
                    pstate = PH_VER_NEG;
                end else if (b >= CH_ZERO && b <= CH_NINE) begin
                    pstate = PH_VER_POS;
                    version_digit(b);
                end else begin
                    give_verdict(EV_REJECT);
                end
            end
            PH_VER_POS, PH_VER_NEG: version_digit(b);
            PH_ENT_KW: match_keyword(b, PH_ENT_NUM);
            PH_ENT_NUM: begin
                if (count_digit(b)) begin
                    n_entries = num_acc;
                    entry_no = 0;
                    if (n_entries == 0)
                        give_verdict(EV_ACCEPT);
                    else
                        pstate = PH_CHAR_KW;
                end
            end
            PH_CHAR_KW: match_keyword(b, PH_CHAR_NUM);
            PH_CHAR_NUM: begin
                if (count_digit(b)) begin
                    left_bytes = num_acc;
                    pstate = (left_bytes != 0) ? PH_CHAR_DATA : PH_CHAR_NL;
                end
            end
            PH_CHAR_DATA: begin
                emit(EV_NAME_BYTE, b, entry_no);
                left_bytes--;
                if (left_bytes == 0)
                    pstate = PH_CHAR_NL;
            end
            PH_CHAR_NL: begin
                if (b == CH_LF) begin
                    emit(EV_NAME_DONE, 8'h00, entry_no);
                    pstate = PH_TEXT_KW;
                    kw_idx = 0;
                end else begin
                    give_verdict(EV_REJECT);
                end
            end
            PH_TEXT_KW: match_keyword(b, PH_TEXT_NUM);
            PH_TEXT_NUM: begin
                if (count_digit(b)) begin
                    left_bytes = num_acc;
                    pstate = (left_bytes != 0) ? PH_TEXT_DATA : PH_TEXT_NL;
                end
            end
            PH_TEXT_DATA: begin
                emit(EV_TEXT_BYTE, b, entry_no);
                left_bytes--;
                if (left_bytes == 0)
                    pstate = PH_TEXT_NL;
            end
            PH_TEXT_NL: begin
                if (b == CH_LF) begin
                    emit(EV_ENTRY_DONE, 8'h00, entry_no);
                    entry_no++;
                    if (entry_no == n_entries) begin
                        give_verdict(EV_ACCEPT);
                    end else begin
                        pstate = PH_CHAR_KW;
                        kw_idx = 0;
                    end
                end else begin
                    give_verdict(EV_REJECT);
                end
            end
            default: pstate = PH_DRAIN;
        endcase

        // End of file rejects an unfinished document and rearms the parser.
        if (eof) begin
            if (!verdict_seen && pstate != PH_DRAIN)
                give_verdict(EV_REJECT);
            clear_parser();
        end
        if (step_res.size() > 0)
            step_res[step_res.size() - 1].last_of_run = 1'b1;
    endfunction

    // ---------------------------------------------------------------
    // Input and output monitor
    // ---------------------------------------------------------------

    always @(posedge i_clk) begin
        t_out_item got;
        t_out_item want;
        // An accepted input item adds its predicted events.
        if (i_rst_n && i_valid && !o_stall) begin
            if (pstate != PH_DRAIN)
                n_useful++;
            n_bytes++;
            deframe_step(i_item.in_byte, i_item.end_of_file);
            if (cur_row.typed) begin
                if (cur_row.n_res == 1)
                    events_due.insert(events_due.size(), t_out_item'{
                        event_kind: cur_row.kind, out_byte: 8'h00, entry_index: 32'd0,
                        last_of_run: 1'b1});
            end else begin
                foreach (step_res[k])
                    events_due.insert(events_due.size(), step_res[k]);
            end
        end

        // An accepted result item is compared with the oldest expectation.
        if (i_rst_n && o_valid && !i_stall) begin
            got = o_item;
            if (events_due.size() == 0) begin
                n_fail++;
                if (n_fail <= MAX_REPORTS)
                    $display("%0t: expected no event, got kind=%0d byte=%02h index=%0d last=%0b",
                             $time, got.event_kind, got.out_byte, got.entry_index,
                             got.last_of_run);
            end else begin
                want = events_due.pop_front();
                n_checked++;
                if (want.event_kind == EV_ACCEPT)
                    n_accepted++;
                if (want.event_kind == EV_REJECT)
                    n_rejected++;
                if (got.event_kind !== want.event_kind || got.out_byte !== want.out_byte
                        || got.entry_index !== want.entry_index
                        || got.last_of_run !== want.last_of_run) begin
                    n_fail++;
                    if (n_fail <= MAX_REPORTS)
                        $display("%0t: expected kind=%0d byte=%02h index=%0d last=%0b, %s",
                                 $time, want.event_kind, want.out_byte, want.entry_index,
                                 want.last_of_run,
                                 $sformatf("got kind=%0d byte=%02h index=%0d last=%0b",
                                           got.event_kind, got.out_byte, got.entry_index,
                                           got.last_of_run));
                end
            end
        end
    end

    // Receiver: random stalls, plus one long hold-off on request.
    always @(posedge i_clk) begin
        if (hold_go) begin
            hold_left = HOLD_CYCLES;
            hold_go = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_stall <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(99) < recv_hold_pct);
        end
    end

    // ---------------------------------------------------------------
    // Stimulus
    // ---------------------------------------------------------------

    function automatic t_stim_row mk_row(logic [7:0] b, logic eof, bit typed, int n,
                                         t_kind k);
        mk_row = '{b: b, eof: eof, typed: typed, n_res: n, kind: k};
    endfunction

    // Appends one row to the directed table.
    function automatic void add_row(t_stim_row r);
        dir_rows.insert(dir_rows.size(), r);
    endfunction

    // Appends one byte to the document under construction.
    function automatic void add_byte(logic [7:0] b);
        doc_q.insert(doc_q.size(), b);
    endfunction

    // Offers one item and returns at the edge where it is taken.
    task automatic send_item(input t_stim_row r);
        while ($urandom_range(99) < send_gap_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_item <= t_in_item'{in_byte: r.b, end_of_file: r.eof};
        cur_row <= r;
        @(posedge i_clk);
        while (o_stall)
            @(posedge i_clk);
    endtask

    task automatic drain_results(input int extra);
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (events_due.size() != 0)
            @(posedge i_clk);
        repeat (extra) @(posedge i_clk);
    endtask

    task automatic write_version(input logic [7:0] v);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        cfg_version = v;
        n_settings++;
    endtask

    function automatic void push_number(longint unsigned v, int zeros);
        logic [7:0] digs[$];
        repeat (zeros) add_byte(CH_ZERO);
        do begin
            digs.push_front(8'(CH_ZERO + v % 10));
            v = v / 10;
        end while (v != 0);
        foreach (digs[i])
            add_byte(digs[i]);
    endfunction

    // Mostly short fields; now and then the widest count and one past it.
    function automatic longint unsigned pick_len();
        int r;
        r = $urandom_range(99);
        if (r < 1)
            return 64'd4294967295;
        if (r < 2)
            return 64'd4294967296;
        if (r < 3)
            return 64'd99999999999;
        if (r < 12)
            return $urandom_range(6, 14);
        return $urandom_range(0, 5);
    endfunction

    // Builds one document: mostly well formed with random content, some damaged or noise.
    function automatic void build_doc();
        int r;
        int n_ent;
        int n_data;
        int k;
        longint unsigned cnt;
        longint unsigned vval;
        longint unsigned flen;
        doc_q.delete();
        r = $urandom_range(99);
        if (r < 8) begin
            repeat ($urandom_range(1, 10)) add_byte(8'($urandom));
            return;
        end

        // Header line with a version in any of its accepted spellings.
        for (int i = 0; i <= HDR_LAST; i++)
            add_byte(HDR_KW[i]);
        repeat ($urandom_range(0, 2)) begin
            case ($urandom_range(4))
                0: add_byte(CH_SPACE);
                1: add_byte(CH_TAB);
                2: add_byte(CH_VT);
                3: add_byte(CH_FF);
                default: add_byte(CH_CR);
            endcase
        end
        r = $urandom_range(99);
        if (cfg_version == 8'd0 && r < 40)
            add_byte(CH_MINUS);
        else if (r < 25)
            add_byte(CH_PLUS);
        else if (r < 30)
            add_byte(CH_MINUS);
        r = $urandom_range(99);
        if (r < 80)
            vval = cfg_version;
        else if (r < 88)
            vval = cfg_version + 256;
        else if (r < 92)
            vval = 99999;
        else
            vval = $urandom_range(255);
        push_number(vval, $urandom_range(0, 2));
        add_byte(CH_LF);

        // Entry count line.
        for (int i = 0; i <= ENT_LAST; i++)
            add_byte(ENT_KW[i]);
        cnt = ($urandom_range(9) == 0) ? pick_len() : longint'($urandom_range(0, 3));
        push_number(cnt, $urandom_range(0, 1));
        add_byte(CH_LF);
        n_ent = (cnt > 20) ? $urandom_range(0, 2) : int'(cnt);

        // Name and text field of each entry.
        for (int e = 0; e < n_ent; e++) begin
            for (int f = 0; f < 2; f++) begin
                for (int i = 0; i <= FLD_LAST; i++)
                    add_byte((f == 0) ? CHAR_KW[i] : TEXT_KW[i]);
                flen = pick_len();
                push_number(flen, $urandom_range(0, 1));
                add_byte(CH_LF);
                n_data = (flen > 64) ? $urandom_range(0, 8) : int'(flen);
                repeat (n_data) add_byte(8'($urandom));
                add_byte(CH_LF);
            end
        end

        // Damage: a corrupted byte, an early end, or trailing bytes.
        r = $urandom_range(99);
        if (r < 15) begin
            k = $urandom_range(0, doc_q.size() - 1);
            doc_q[k] = 8'($urandom);
        end else if (r < 25) begin
            k = $urandom_range(0, doc_q.size() - 1);
            doc_q = doc_q[0:k];
        end else if (r < 55) begin
            repeat ($urandom_range(1, 4)) add_byte(8'($urandom));
        end
    endfunction

    task automatic run_doc();
        int pause_at;
        build_doc();
        pause_at = ($urandom_range(24) == 0) ? $urandom_range(0, doc_q.size() - 1) : -1;
        foreach (doc_q[i]) begin
            send_item(mk_row(doc_q[i], i == doc_q.size() - 1, 1'b0, 0, EV_REJECT));
            // Occasionally the sender waits mid-document for every result.
            if (i == pause_at)
                drain_results(0);
        end
        n_docs++;
    endtask

    initial begin
        logic [7:0] next_ver;
        int quota;
        i_rst_n <= 1'b0;
        i_valid <= 1'b0;
        i_item <= '0;
        i_stall <= 1'b0;
        i_cfg_we <= 1'b0;
        i_cfg_wdata <= '0;
        cur_row <= mk_row(8'h00, 1'b0, 1'b0, 0, EV_REJECT);
        cfg_version = 8'd1;
        clear_parser();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed sequence, run at the reset version.
        // A wrong first byte is rejected at once.
        add_row(mk_row(8'h00, 1'b0, 1'b1, 1, EV_REJECT));
        // Bytes after the verdict are ignored, and end of file rearms.
        add_row(mk_row(8'hFF, 1'b1, 1'b1, 0, EV_REJECT));
        // A document that ends on its first byte is rejected.
        add_row(mk_row(HDR_KW[0], 1'b1, 1'b1, 1, EV_REJECT));
        for (int i = 0; i <= HDR_LAST; i++)
            add_row(mk_row(HDR_KW[i], 1'b0, 1'b0, 0, EV_REJECT));
        add_row(mk_row(CH_MINUS, 1'b0, 1'b0, 0, EV_REJECT));
        add_row(mk_row(CH_ZERO, 1'b0, 1'b0, 0, EV_REJECT));
        // Negative zero is version zero, which does not match version one.
        add_row(mk_row(CH_LF, 1'b0, 1'b1, 1, EV_REJECT));
        add_row(mk_row(8'hFF, 1'b1, 1'b1, 0, EV_REJECT));
        foreach (dir_rows[i])
            send_item(dir_rows[i]);
        drain_results(SETTLE_CYCLES);

        // Random documents in phases, each with its own version and idling.
        for (int p = 0; p < N_PHASES; p++) begin
            case (p)
                0: next_ver = 8'd0;
                1: next_ver = 8'd255;
                N_PHASES - 1: next_ver = 8'd1;
                default: next_ver = 8'($urandom_range(2, 254));
            endcase
            write_version(next_ver);
            case (p % 4)
                0: begin
                    send_gap_pct = 0;
                    recv_hold_pct = 0;
                end
                1: begin
                    send_gap_pct = 57;
                    recv_hold_pct = 0;
                end
                2: begin
                    send_gap_pct = 0;
                    recv_hold_pct = 57;
                end
                default: begin
                    send_gap_pct = 11;
                    recv_hold_pct = 11;
                end
            endcase
            // The receiver holds off for a long stretch while items keep coming.
            if (p == 4)
                hold_go = 1'b1;
            quota = ITEM_TARGET * (p + 1) / N_PHASES;
            while (n_bytes < quota)
                run_doc();
            drain_results(SETTLE_CYCLES);
        end

        repeat (2 * SETTLE_CYCLES) @(posedge i_clk);
        $display("Sent %0d bytes (%0d before a verdict) in %0d random documents and a directed run.",
                 n_bytes, n_useful, n_docs);
        $display("Checked %0d events (%0d accepted, %0d rejected) over %0d versions.",
                 n_checked, n_accepted, n_rejected, n_settings + 1);
        if (n_fail == 0 && events_due.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

FILE: sim.f
src/lprd_pkg.sv
src/lprd_parser.sv
src/lprd_outq.sv
src/length_prefixed_record_deframer_core.sv
dv/tb_top.sv
